>>> rtl/core/integer_to_ascii_formatter_macros.svh
// Assertion macros shared by the formatter RTL.
`ifndef INTEGER_TO_ASCII_FORMATTER_MACROS_SVH
`define INTEGER_TO_ASCII_FORMATTER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ITOAF_ASSERT_IMP(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("itoaf same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define ITOAF_ASSERT_NEXT(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("itoaf next-cycle check failed");

`endif

>>> rtl/core/itoaf_pkg.sv
package itoaf_pkg;

    localparam int QUEUE_DEPTH = 2;
    localparam int MAX_DIGITS  = 10;
    localparam int RECIP_SHIFT = 35;

    localparam logic [31:0] RECIP_TEN    = 32'hCCCC_CCCD;
    localparam logic [7:0]  CHAR_ZERO    = 8'h30;
    localparam logic [7:0]  CHAR_LOWER_A = 8'h61;
    localparam logic [7:0]  CHAR_UPPER_A = 8'h41;
    localparam logic [7:0]  CHAR_MINUS   = 8'h2D;

    typedef enum logic [1:0] {
        OP_SDEC = 2'd0,
        OP_UDEC = 2'd1,
        OP_HEXL = 2'd2,
        OP_HEXU = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIGIT,
        ST_EMIT
    } state_t;

    // One classified item as it travels from the front to the back.
    typedef struct packed {
        logic [31:0] mag;
        logic        neg;
        logic        hex;
        logic        upper;
    } entry_t;

    function automatic logic [7:0] to_ascii(input logic [3:0] digit, input logic upper);
        logic [7:0] letter;
        begin
            letter = upper ? CHAR_UPPER_A : CHAR_LOWER_A;
            if (digit <= 4'd9) begin
                to_ascii = CHAR_ZERO + {4'b0, digit};
            end else begin
                to_ascii = letter + {4'b0, digit} - 8'd10;
            end
        end
    endfunction

endpackage

>>> rtl/core/itoaf_front.sv
module itoaf_front (
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [31:0]            s_value,
    input  logic [1:0]             s_operation,
    output logic                   push_valid,
    input  logic                   push_ready,
    output itoaf_pkg::entry_t      push_entry
);

    logic [31:0] negated;

    assign negated    = ~s_value + 32'd1;
    assign s_ready    = push_ready;
    assign push_valid = s_valid;

    always_comb begin
        push_entry.mag   = s_value;
        push_entry.neg   = 1'b0;
        push_entry.hex   = 1'b0;
        push_entry.upper = 1'b0;
        unique case (itoaf_pkg::op_t'(s_operation))
            itoaf_pkg::OP_SDEC: begin
                if (s_value[31]) begin
                    push_entry.neg = 1'b1;
                    push_entry.mag = negated;
                end
            end
            itoaf_pkg::OP_UDEC: begin
                push_entry.neg = 1'b0;
            end
            itoaf_pkg::OP_HEXL: begin
                push_entry.hex = 1'b1;
            end
            itoaf_pkg::OP_HEXU: begin
                push_entry.hex   = 1'b1;
                push_entry.upper = 1'b1;
            end
            default: begin
                push_entry.hex = 1'b0;
            end
        endcase
    end

endmodule

>>> rtl/core/itoaf_queue.sv
module itoaf_queue (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  itoaf_pkg::entry_t      in_entry,
    output logic                   out_valid,
    input  logic                   out_ready,
    output itoaf_pkg::entry_t      out_entry
);

    localparam int PTR_W = $clog2(itoaf_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(itoaf_pkg::QUEUE_DEPTH + 1);

    itoaf_pkg::entry_t slot_reg [itoaf_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              push, pop;

    assign in_ready  = (count_reg != CNT_W'(itoaf_pkg::QUEUE_DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_entry = slot_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(itoaf_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                             : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(itoaf_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                             : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= in_entry;
        end
    end

endmodule

>>> rtl/core/itoaf_back.sv
module itoaf_back (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   pop_valid,
    output logic                   pop_ready,
    input  itoaf_pkg::entry_t      pop_entry,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [7:0]             m_character,
    output logic                   m_last,
    output logic [3:0]             m_char_count
);

    localparam int IDX_W = $clog2(itoaf_pkg::MAX_DIGITS);

    itoaf_pkg::state_t state_reg, state_next;

    logic [31:0]      mag_reg, mag_next;
    logic [63:0]      prod_reg, prod_next;
    logic             neg_reg, neg_next;
    logic             hex_reg, hex_next;
    logic             upper_reg, upper_next;
    logic             sign_reg, sign_next;
    logic [3:0]       ndig_reg, ndig_next;
    logic [IDX_W-1:0] pos_reg, pos_next;
    logic [3:0]       digit_reg [itoaf_pkg::MAX_DIGITS];

    logic             m_valid_reg, m_valid_next;
    logic [7:0]       m_character_reg, m_character_next;
    logic             m_last_reg, m_last_next;
    logic [3:0]       m_char_count_reg, m_char_count_next;

    logic [31:0]      dec_quot, dec_times_ten, dec_rem, quot;
    logic [3:0]       digit;
    logic             digit_done;
    logic             out_free;
    logic             digit_write;

    assign out_free      = !m_valid_reg || m_ready;
    assign dec_quot      = 32'(prod_reg >> itoaf_pkg::RECIP_SHIFT);
    assign dec_times_ten = {dec_quot[28:0], 3'b000} + {dec_quot[30:0], 1'b0};
    assign dec_rem       = mag_reg - dec_times_ten;
    assign quot          = hex_reg ? {4'b0000, mag_reg[31:4]} : dec_quot;
    assign digit         = hex_reg ? mag_reg[3:0] : dec_rem[3:0];
    assign digit_done    = (quot == 32'd0) || (ndig_reg == 4'(itoaf_pkg::MAX_DIGITS - 1));
    assign digit_write   = (state_reg == itoaf_pkg::ST_DIGIT);

    assign pop_ready    = (state_reg == itoaf_pkg::ST_IDLE);
    assign m_valid      = m_valid_reg;
    assign m_character  = m_character_reg;
    assign m_last       = m_last_reg;
    assign m_char_count = m_char_count_reg;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            itoaf_pkg::ST_IDLE: begin
                if (pop_valid) begin
                    state_next = pop_entry.hex ? itoaf_pkg::ST_DIGIT : itoaf_pkg::ST_MUL;
                end
            end
            itoaf_pkg::ST_MUL: begin
                state_next = itoaf_pkg::ST_DIGIT;
            end
            itoaf_pkg::ST_DIGIT: begin
                if (digit_done) begin
                    state_next = itoaf_pkg::ST_EMIT;
                end else if (!hex_reg) begin
                    state_next = itoaf_pkg::ST_MUL;
                end
            end
            itoaf_pkg::ST_EMIT: begin
                if (out_free && !sign_reg && pos_reg == '0) begin
                    state_next = itoaf_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = itoaf_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        mag_next          = mag_reg;
        prod_next         = prod_reg;
        neg_next          = neg_reg;
        hex_next          = hex_reg;
        upper_next        = upper_reg;
        sign_next         = sign_reg;
        ndig_next         = ndig_reg;
        pos_next          = pos_reg;
        m_valid_next      = m_ready ? 1'b0 : m_valid_reg;
        m_character_next  = m_character_reg;
        m_last_next       = m_last_reg;
        m_char_count_next = m_char_count_reg;
        unique case (state_reg)
            itoaf_pkg::ST_IDLE: begin
                if (pop_valid) begin
                    mag_next   = pop_entry.mag;
                    neg_next   = pop_entry.neg;
                    hex_next   = pop_entry.hex;
                    upper_next = pop_entry.upper;
                    ndig_next  = 4'd0;
                end
            end
            itoaf_pkg::ST_MUL: begin
                prod_next = {32'd0, mag_reg} * {32'd0, itoaf_pkg::RECIP_TEN};
            end
            itoaf_pkg::ST_DIGIT: begin
                mag_next  = quot;
                ndig_next = ndig_reg + 4'd1;
                if (digit_done) begin
                    pos_next  = ndig_reg[IDX_W-1:0];
                    sign_next = neg_reg;
                end
            end
            itoaf_pkg::ST_EMIT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    if (sign_reg) begin
                        sign_next         = 1'b0;
                        m_character_next  = itoaf_pkg::CHAR_MINUS;
                        m_last_next       = 1'b0;
                        m_char_count_next = 4'd0;
                    end else begin
                        m_character_next = itoaf_pkg::to_ascii(digit_reg[pos_reg], upper_reg);
                        if (pos_reg == '0) begin
                            m_last_next       = 1'b1;
                            m_char_count_next = ndig_reg + {3'b000, neg_reg};
                        end else begin
                            m_last_next       = 1'b0;
                            m_char_count_next = 4'd0;
                            pos_next          = pos_reg - 1'b1;
                        end
                    end
                end
            end
            default: begin
                ndig_next = ndig_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= itoaf_pkg::ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        mag_reg          <= mag_next;
        prod_reg         <= prod_next;
        neg_reg          <= neg_next;
        hex_reg          <= hex_next;
        upper_reg        <= upper_next;
        sign_reg         <= sign_next;
        ndig_reg         <= ndig_next;
        pos_reg          <= pos_next;
        m_character_reg  <= m_character_next;
        m_last_reg       <= m_last_next;
        m_char_count_reg <= m_char_count_next;
        if (digit_write) begin
            digit_reg[ndig_reg[IDX_W-1:0]] <= digit;
        end
    end

endmodule

>>> rtl/core/integer_to_ascii_formatter.sv
// Formats one 32-bit number per input item as ASCII text, most significant character first.
// Input channel: s_valid/s_ready with s_value and s_operation (signed decimal, unsigned
// decimal, lowercase hex, uppercase hex). Output channel: m_valid/m_ready with one character
// per item, m_last on the final character and m_char_count (total length) on that character.
// The front classifies each item and takes the sign and magnitude; a two-entry queue holds
// classified items so that new numbers are taken while the back still converts or emits.
// The back extracts digits least significant first into a small buffer: a hex digit takes
// the DIGIT state alone, a decimal digit the MUL state (a registered multiply by the
// reciprocal of ten) and then the DIGIT state (the quotient and remainder). It then sends
// any minus sign and then the digits one per cycle while the receiver holds m_ready high.
// Reset, synchronous and active low, empties the queue, returns the back to idle and
// drops m_valid. When the receiver holds m_ready low, the current character stays on the
// output, the back waits, and the queue then fills and drops s_ready.
`include "integer_to_ascii_formatter_macros.svh"

module integer_to_ascii_formatter (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_value,
    input  logic [1:0]  s_operation,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_character,
    output logic        m_last,
    output logic [3:0]  m_char_count
);

    logic              push_valid, push_ready;
    logic              pop_valid, pop_ready;
    itoaf_pkg::entry_t push_entry, pop_entry;
    logic              last_count_ok;
    logic              minus_out;

    assign last_count_ok = (m_char_count != 4'd0) && (m_char_count <= 4'd11);
    assign minus_out     = m_valid && (m_character == itoaf_pkg::CHAR_MINUS);

    itoaf_front u_front (
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_value     (s_value),
        .s_operation (s_operation),
        .push_valid  (push_valid),
        .push_ready  (push_ready),
        .push_entry  (push_entry)
    );

    itoaf_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (push_valid),
        .in_ready  (push_ready),
        .in_entry  (push_entry),
        .out_valid (pop_valid),
        .out_ready (pop_ready),
        .out_entry (pop_entry)
    );

    itoaf_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .pop_valid    (pop_valid),
        .pop_ready    (pop_ready),
        .pop_entry    (pop_entry),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_character  (m_character),
        .m_last       (m_last),
        .m_char_count (m_char_count)
    );

    `ITOAF_ASSERT_IMP(a_last_count, aclk, aresetn, m_valid && m_last, last_count_ok)
    `ITOAF_ASSERT_IMP(a_mid_count, aclk, aresetn, m_valid && !m_last, m_char_count == 4'd0)
    `ITOAF_ASSERT_IMP(a_minus_first, aclk, aresetn, minus_out, !m_last)
    `ITOAF_ASSERT_NEXT(a_no_gap, aclk, aresetn, m_valid && m_ready && !m_last, m_valid)

endmodule
